// ===== hdl/spf_pkg.sv =====
// ============================================================================
// spf_pkg
// Shared widths, divider handshake types and the sequencer microprogram for
// the smallest-prime-factor factorizer.
// ============================================================================
`default_nettype none

package spf_pkg;

    // Width of the value and factor fields
    localparam int FIELD_W   = 12;
    // Default table span (values below this are factored)
    localparam int MAX_N_DEF = 4096;
    // Largest table the field width can ever address
    localparam int TABLE_CAP = 1 << FIELD_W;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [FIELD_W-1:0] quotient;
    } div_rsp_t;

    // Microprogram step address
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    // Table memory operation of a step
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_I,
        MEM_RD_J,
        MEM_RD_V,
        MEM_WR_INDEX,
        MEM_WR_SIEVE
    } mem_op_t;

    // Sieve walk register j
    typedef enum logic [2:0] {
        J_HOLD,
        J_CLR,
        J_INC,
        J_SQ,
        J_ADD_I
    } j_op_t;

    // Sieve base register i
    typedef enum logic [1:0] {
        I_HOLD,
        I_SET2,
        I_INC
    } i_op_t;

    // Working value register v
    typedef enum logic [1:0] {
        V_HOLD,
        V_IN,
        V_QUOT
    } v_op_t;

    // Result register load
    typedef enum logic [1:0] {
        O_NONE,
        O_FACTOR,
        O_EMPTY
    } out_op_t;

    // Branch condition
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_J_NOT_LAST,
        C_I_SQ_OVER,
        C_NOT_PRIME,
        C_J_NEXT_IN,
        C_NO_INPUT,
        C_TRIVIAL,
        C_DIV_BUSY,
        C_OUT_STALL,
        C_V_NOT_ONE
    } cond_t;

    // One control word. With wait_en set, a true condition holds the step
    // and suppresses its register actions, but not its table memory operation.
    typedef struct packed {
        mem_op_t mem_op;
        j_op_t   j_op;
        i_op_t   i_op;
        v_op_t   v_op;
        out_op_t out_op;
        logic    div_start;
        logic    ld_p;
        logic    in_rdy;
        logic    wait_en;
        cond_t   cond;
        step_t   target;
    } uword_t;

    // Step addresses
    localparam step_t ST_INIT_CLR  = 5'd0;
    localparam step_t ST_INIT_FILL = 5'd1;
    localparam step_t ST_I_SET     = 5'd2;
    localparam step_t ST_I_READ    = 5'd3;
    localparam step_t ST_I_TEST    = 5'd4;
    localparam step_t ST_J_READ    = 5'd5;
    localparam step_t ST_J_MARK    = 5'd6;
    localparam step_t ST_I_NEXT    = 5'd7;
    localparam step_t ST_IDLE      = 5'd8;
    localparam step_t ST_CHECK     = 5'd9;
    localparam step_t ST_V_READ    = 5'd10;
    localparam step_t ST_DIV_GO    = 5'd11;
    localparam step_t ST_DIV_WAIT  = 5'd12;
    localparam step_t ST_EMIT      = 5'd13;
    localparam step_t ST_LOOP      = 5'd14;
    localparam step_t ST_DONE      = 5'd15;
    localparam step_t ST_EMPTY     = 5'd16;
    localparam step_t ST_EMPTY_END = 5'd17;

    localparam uword_t UW_NOP = '{
        mem_op:    MEM_NONE,
        j_op:      J_HOLD,
        i_op:      I_HOLD,
        v_op:      V_HOLD,
        out_op:    O_NONE,
        div_start: 1'b0,
        ld_p:      1'b0,
        in_rdy:    1'b0,
        wait_en:   1'b0,
        cond:      C_NEVER,
        target:    ST_INIT_CLR
    };

    // Microprogram ROM
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = UW_NOP;
        unique case (s)
            // Fill every entry with its own index
            ST_INIT_CLR:
            begin
                w.j_op = J_CLR;
            end
            ST_INIT_FILL:
            begin
                w.mem_op = MEM_WR_INDEX;
                w.j_op   = J_INC;
                w.cond   = C_J_NOT_LAST;
                w.target = ST_INIT_FILL;
            end
            // Sieve over bases i while i*i stays inside the table
            ST_I_SET:
            begin
                w.i_op = I_SET2;
            end
            ST_I_READ:
            begin
                w.mem_op = MEM_RD_I;
                w.cond   = C_I_SQ_OVER;
                w.target = ST_IDLE;
            end
            ST_I_TEST:
            begin
                w.j_op   = J_SQ;
                w.cond   = C_NOT_PRIME;
                w.target = ST_I_NEXT;
            end
            ST_J_READ:
            begin
                w.mem_op = MEM_RD_J;
            end
            ST_J_MARK:
            begin
                w.mem_op = MEM_WR_SIEVE;
                w.j_op   = J_ADD_I;
                w.cond   = C_J_NEXT_IN;
                w.target = ST_J_READ;
            end
            ST_I_NEXT:
            begin
                w.i_op   = I_INC;
                w.cond   = C_ALWAYS;
                w.target = ST_I_READ;
            end
            // Wait for a value
            ST_IDLE:
            begin
                w.in_rdy  = 1'b1;
                w.v_op    = V_IN;
                w.wait_en = 1'b1;
                w.cond    = C_NO_INPUT;
                w.target  = ST_IDLE;
            end
            ST_CHECK:
            begin
                w.cond   = C_TRIVIAL;
                w.target = ST_EMPTY;
            end
            // Look up, divide, emit, repeat
            ST_V_READ:
            begin
                w.mem_op = MEM_RD_V;
            end
            ST_DIV_GO:
            begin
                w.div_start = 1'b1;
                w.ld_p      = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                w.wait_en = 1'b1;
                w.cond    = C_DIV_BUSY;
                w.target  = ST_DIV_WAIT;
            end
            ST_EMIT:
            begin
                w.out_op  = O_FACTOR;
                w.v_op    = V_QUOT;
                w.wait_en = 1'b1;
                w.cond    = C_OUT_STALL;
                w.target  = ST_EMIT;
            end
            ST_LOOP:
            begin
                w.cond   = C_V_NOT_ONE;
                w.target = ST_V_READ;
            end
            ST_DONE:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            // Single result for a value with no factors
            ST_EMPTY:
            begin
                w.out_op  = O_EMPTY;
                w.wait_en = 1'b1;
                w.cond    = C_OUT_STALL;
                w.target  = ST_EMPTY;
            end
            ST_EMPTY_END:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/spf_if.sv =====
// ============================================================================
// spf_if
// Valid/ready channels of the factorizer: value input and factor output.
// ============================================================================
`default_nettype none

interface spf_in_if;
    logic                        valid;
    logic                        ready;
    logic [spf_pkg::FIELD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface spf_out_if;
    logic                        valid;
    logic                        ready;
    logic [spf_pkg::FIELD_W-1:0] factor;
    logic                        last;
    logic                        no_factors;

    modport source (output valid, output factor, output last, output no_factors, input ready);
    modport sink   (input valid, input factor, input last, input no_factors, output ready);
endinterface

`default_nettype wire

// ===== hdl/prime_factorizer_spf.sv =====
// ============================================================================
// prime_factorizer_spf
// Prime factorization by smallest-prime-factor table. A microcoded sequencer
// builds the table once after reset, then factors one value per transfer,
// giving its prime factors in ascending order, one per result transfer.
// ============================================================================
//
//  channel  | dir | payload                          | transfer
//  ---------+-----+----------------------------------+-------------------------
//  item     | in  | value[11:0]                      | valid && ready
//  result   | out | factor[11:0], last, no_factors   | valid && ready
//
//  After reset the table is filled (D entries, D = min(MAX_N, 4096)) and then
//  sieved; item.ready stays low until this is done.
//  For a value with k prime factors, each factor costs one table read, a pass
//  through the divider and the emit. Values 0, 1 and values at or above
//  MAX_N give a single no_factors result.
//  The result register frees the sequencer; a stalled result holds only the
//  next emit step.
// ============================================================================
`default_nettype none

module prime_factorizer_spf #(
    parameter int MAX_N = spf_pkg::MAX_N_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spf_in_if.sink     item,
    spf_out_if.source  result
);
    import spf_pkg::*;

    localparam int DEPTH = (MAX_N < TABLE_CAP) ? MAX_N : TABLE_CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = AW + 1;
    localparam int SQW   = 2 * JW;

    // Sequencer
    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   cond_true;
    logic   act;

    // Datapath registers
    logic [JW-1:0]      i_reg;
    logic [JW-1:0]      i_next;
    logic [JW-1:0]      j_reg;
    logic [JW-1:0]      j_next;
    logic [FIELD_W-1:0] v_reg;
    logic [FIELD_W-1:0] v_next;
    logic [FIELD_W-1:0] p_reg;
    logic [FIELD_W-1:0] p_next;
    logic               table_ready_reg;
    logic               table_ready_next;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FIELD_W-1:0] out_factor_reg;
    logic [FIELD_W-1:0] out_factor_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_nf_reg;
    logic               out_nf_next;
    logic               out_stall;

    // Table memory
    logic [FIELD_W-1:0] spf_mem [DEPTH];
    logic [FIELD_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [FIELD_W-1:0] wr_data;

    // Datapath helpers
    logic [SQW-1:0]     i_sq;
    logic [JW-1:0]      j_sum;
    logic               trivial;

    div_req_t div_req;
    div_rsp_t div_rsp;

    spf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign uw        = ucode(step_reg);
    assign i_sq      = SQW'(i_reg) * SQW'(i_reg);
    assign j_sum     = j_reg + i_reg;
    assign trivial   = (v_reg < FIELD_W'(2)) || (32'(v_reg) >= 32'(MAX_N));
    assign out_stall = out_valid_reg && !result.ready;

    // Evaluate the branch condition of the current step
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_J_NOT_LAST: cond_true = (j_reg != JW'(DEPTH - 1));
            C_I_SQ_OVER:  cond_true = (i_sq >= SQW'(DEPTH));
            C_NOT_PRIME:  cond_true = (rd_data_reg != FIELD_W'(i_reg));
            C_J_NEXT_IN:  cond_true = (j_sum < JW'(DEPTH));
            C_NO_INPUT:   cond_true = !item.valid;
            C_TRIVIAL:    cond_true = trivial;
            C_DIV_BUSY:   cond_true = div_rsp.busy;
            C_OUT_STALL:  cond_true = out_stall;
            C_V_NOT_ONE:  cond_true = (v_reg != FIELD_W'(1));
            default:      cond_true = 1'b0;
        endcase
    end

    // Suppress actions of a held step; branch or advance
    assign act       = !(uw.wait_en && cond_true);
    assign step_next = cond_true ? uw.target : step_reg + 1'b1;

    // Decode the memory operation
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = j_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = j_reg[AW-1:0];
        wr_data = FIELD_W'(j_reg);
        unique case (uw.mem_op)
            MEM_NONE:
            begin
            end
            MEM_RD_I:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg[AW-1:0];
            end
            MEM_RD_J:
            begin
                rd_en = 1'b1;
            end
            MEM_RD_V:
            begin
                rd_en   = 1'b1;
                rd_addr = v_reg[AW-1:0];
            end
            MEM_WR_INDEX:
            begin
                wr_en = 1'b1;
            end
            MEM_WR_SIEVE:
            begin
                wr_en   = (rd_data_reg == FIELD_W'(j_reg));
                wr_data = FIELD_W'(i_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Access the table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            spf_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= spf_mem[rd_addr];
        end
    end

    // Start the divider on the looked-up factor
    assign div_req.start    = uw.div_start && act;
    assign div_req.dividend = v_reg;
    assign div_req.divisor  = rd_data_reg;

    // Next values of the datapath registers
    always_comb
    begin
        i_next           = i_reg;
        j_next           = j_reg;
        v_next           = v_reg;
        p_next           = p_reg;
        table_ready_next = table_ready_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_factor_next  = out_factor_reg;
        out_last_next    = out_last_reg;
        out_nf_next      = out_nf_reg;

        if (act)
        begin
            unique case (uw.i_op)
                I_HOLD:  i_next = i_reg;
                I_SET2:  i_next = JW'(2);
                I_INC:   i_next = i_reg + 1'b1;
                default: i_next = i_reg;
            endcase

            unique case (uw.j_op)
                J_HOLD:  j_next = j_reg;
                J_CLR:   j_next = '0;
                J_INC:   j_next = j_reg + 1'b1;
                J_SQ:    j_next = i_sq[JW-1:0];
                J_ADD_I: j_next = j_sum;
                default: j_next = j_reg;
            endcase

            unique case (uw.v_op)
                V_HOLD:  v_next = v_reg;
                V_IN:    v_next = item.value;
                V_QUOT:  v_next = div_rsp.quotient;
                default: v_next = v_reg;
            endcase

            if (uw.ld_p)
            begin
                p_next = rd_data_reg;
            end

            unique case (uw.out_op)
                O_NONE:
                begin
                end
                O_FACTOR:
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = p_reg;
                    out_last_next   = (div_rsp.quotient == FIELD_W'(1));
                    out_nf_next     = 1'b0;
                end
                O_EMPTY:
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = '0;
                    out_last_next   = 1'b1;
                    out_nf_next     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Mark the table built when the sieve runs out of bases
        if ((uw.cond == C_I_SQ_OVER) && cond_true)
        begin
            table_ready_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_INIT_CLR;
            table_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg        <= step_next;
            table_ready_reg <= table_ready_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        v_reg          <= v_next;
        p_reg          <= p_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
        out_nf_reg     <= out_nf_next;
    end

    assign item.ready        = uw.in_rdy && table_ready_reg;
    assign result.valid      = out_valid_reg;
    assign result.factor     = out_factor_reg;
    assign result.last       = out_last_reg;
    assign result.no_factors = out_nf_reg;

`ifndef SYNTH
    // No value is taken before the table is complete
    assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> table_ready_reg)
        else $error("input ready before table built");

    // A listed factor is always a real prime candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.no_factors) |-> (result.factor >= FIELD_W'(2)))
        else $error("factor below two");

    // The divider is never restarted mid-operation
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Table writes, fill and sieve alike, stay inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (j_reg < JW'(DEPTH)))
        else $error("table write out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/spf_div.sv =====
// ============================================================================
// spf_div
// Restoring divider, one quotient bit per cycle. Busy from a start until the
// last bit is in; the quotient register is final once busy drops.
// ============================================================================
`default_nettype none

module spf_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  spf_pkg::div_req_t      req,
    output spf_pkg::div_rsp_t      rsp
);
    import spf_pkg::*;

    localparam int CW = $clog2(FIELD_W + 1);

    logic [FIELD_W-1:0] rem_reg;
    logic [FIELD_W-1:0] rem_next;
    logic [FIELD_W-1:0] quot_reg;
    logic [FIELD_W-1:0] quot_next;
    logic [FIELD_W-1:0] dsr_reg;
    logic [FIELD_W-1:0] dsr_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [FIELD_W:0]   trial;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quot_reg[FIELD_W-1]} - {1'b0, dsr_reg};

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            rem_next  = '0;
            quot_next = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CW'(FIELD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[FIELD_W])
            begin
                rem_next  = trial[FIELD_W-1:0];
                quot_next = {quot_reg[FIELD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[FIELD_W-2:0], quot_reg[FIELD_W-1]};
                quot_next = {quot_reg[FIELD_W-2:0], 1'b0};
            end
        end
    end

    // Hold the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the smallest-prime-factor factorizer. A driver feeds
// values from a queue and a monitor checks every factor transfer against
// factor lists worked out from a local sieve table. Both channels idle at
// random in some phases. One phase holds the result side off for a long
// stretch, and the sender drains between phases.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spf_pkg::*;

    localparam int TABLE_SPAN   = MAX_N_DEF;
    localparam int MAX_FACTORS  = 11;
    localparam int IDLE_PCT     = 35;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE_CYCLES = 250;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [FIELD_W-1:0] factor;
        logic               last;
        logic               no_factors;
    } factor_t;

    logic clk;
    logic rst_n;
    logic result_hold;
    event hold_request;

    spf_in_if  item_ch ();
    spf_out_if result_ch ();

    prime_factorizer_spf #(
        .MAX_N(TABLE_SPAN)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch)
    );

    // Local sieve table and pending work
    logic [FIELD_W-1:0] smallest_factor [TABLE_SPAN];
    logic [FIELD_W-1:0] pending_values [$];
    factor_t            expected_factors [$];
    factor_t            head_factor;

    int idle_pct;
    int values_queued;
    int values_accepted = 0;
    int factors_checked = 0;
    int empties_checked = 0;
    int most_factors = 0;
    int error_count = 0;

    // Fill the table: every entry its own index, then mark multiples by base
    function automatic void build_factor_table();
        int unsigned base;
        int unsigned mult;
        for (int unsigned n = 0; n < TABLE_SPAN; n++)
            smallest_factor[n] = FIELD_W'(n);
        for (base = 2; base * base < TABLE_SPAN; base++)
        begin
            if (smallest_factor[base] == base)
            begin
                for (mult = base * base; mult < TABLE_SPAN; mult += base)
                begin
                    if (smallest_factor[mult] == mult)
                        smallest_factor[mult] = FIELD_W'(base);
                end
            end
        end
    endfunction

    // Queue the factor list that one accepted value must produce
    function automatic void predict_factors(logic [FIELD_W-1:0] value);
        int unsigned rest;
        int unsigned p;
        int          count;
        factor_t     entry;
        rest  = value;
        count = 0;
        if (rest < 2 || rest >= TABLE_SPAN)
        begin
            entry.factor     = '0;
            entry.last       = 1'b1;
            entry.no_factors = 1'b1;
            expected_factors.push_back(entry);
        end
        else
        begin
            while (rest > 1 && count < MAX_FACTORS)
            begin
                p = smallest_factor[rest];
                if (p < 2)
                    p = rest;
                rest = rest / p;
                entry.factor     = FIELD_W'(p);
                entry.last       = (rest == 1) || (count == MAX_FACTORS - 1);
                entry.no_factors = 1'b0;
                expected_factors.push_back(entry);
                count++;
            end
            if (count > most_factors)
                most_factors = count;
        end
    endfunction

    function automatic int unsigned random_prime(int unsigned hi);
        int unsigned p;
        p = $urandom_range(hi, 2);
        while (smallest_factor[p] != p)
            p = $urandom_range(hi, 2);
        return p;
    endfunction

    // Draw a value, biased toward long and unusual factor lists
    function automatic logic [FIELD_W-1:0] draw_value();
        int unsigned acc;
        int unsigned p;
        acc = 0;
        case ($urandom_range(9))
            0, 1, 2, 3:
                acc = $urandom_range(TABLE_SPAN - 1);
            4, 5:
            begin
                // Smooth number built from small primes
                acc = 1;
                repeat ($urandom_range(13))
                begin
                    case ($urandom_range(4))
                        0, 1: p = 2;
                        2:    p = 3;
                        3:    p = 5;
                        default: p = 7 + 4 * $urandom_range(1);
                    endcase
                    if (acc * p < TABLE_SPAN)
                        acc = acc * p;
                end
            end
            6:
                acc = random_prime(TABLE_SPAN - 1);
            7:
            begin
                // Prime power
                p   = random_prime(63);
                acc = p;
                while (acc * p < TABLE_SPAN && $urandom_range(3) != 0)
                    acc = acc * p;
            end
            8:
            begin
                // Product of two primes, the first below 64
                p   = random_prime(63);
                acc = p * random_prime((TABLE_SPAN - 1) / p);
            end
            default:
            begin
                case ($urandom_range(4))
                    0: acc = 0;
                    1: acc = 1;
                    2: acc = 2;
                    3: acc = 2048;
                    default: acc = TABLE_SPAN - 1;
                endcase
            end
        endcase
        return FIELD_W'(acc);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_value(input logic [FIELD_W-1:0] value);
        pending_values.push_back(value);
        values_queued++;
    endtask

    // Hold until every queued value has been transferred
    task automatic wait_all_sent();
        while (values_accepted != values_queued)
            @(negedge clk);
    endtask

    // Hold until every expected factor has come back
    task automatic wait_drained();
        while (expected_factors.size() != 0)
            @(negedge clk);
    endtask

    // Reset from time zero, released on a clock edge
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result hold-off, counted here while the sender keeps going
    initial
    begin
        result_hold = 1'b0;
        forever
        begin
            @(hold_request);
            @(posedge clk);
            result_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            result_hold <= 1'b0;
        end
    end

    // Driver: advance to the next value once the current one transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.value <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_factors(item_ch.value);
                values_accepted++;
            end
            if (!(item_ch.valid && !item_ch.ready))
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.value <= pending_values.pop_front();
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                    item_ch.value <= FIELD_W'($urandom);
                end
            end
        end
    end

    // Monitor: check each factor transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_factors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected factor %0d last %0b none %0b",
                        result_ch.factor, result_ch.last, result_ch.no_factors));
                end
                else
                begin
                    head_factor = expected_factors.pop_front();
                    if (result_ch.factor !== head_factor.factor)
                        report_mismatch($sformatf("factor %0d, want %0d",
                            result_ch.factor, head_factor.factor));
                    if (result_ch.last !== head_factor.last)
                        report_mismatch($sformatf("last %0b, want %0b on factor %0d",
                            result_ch.last, head_factor.last, head_factor.factor));
                    if (result_ch.no_factors !== head_factor.no_factors)
                        report_mismatch($sformatf("no_factors %0b, want %0b",
                            result_ch.no_factors, head_factor.no_factors));
                    if (head_factor.no_factors)
                        empties_checked++;
                    factors_checked++;
                end
            end
            result_ch.ready <= !result_hold && ($urandom_range(99) >= idle_pct);
        end
    end

    // Stimulus phases
    initial
    begin
        idle_pct        = IDLE_PCT;
        values_queued   = 0;
        build_factor_table();
        @(negedge clk);

        // Extremes, trivial values, primes and the longest lists
        queue_value(12'd0);
        queue_value(12'd1);
        queue_value(12'd2);
        queue_value(12'd3);
        queue_value(12'd4);
        queue_value(12'd2048);
        queue_value(12'd3072);
        queue_value(12'd4095);
        queue_value(12'd4094);
        queue_value(12'd4093);
        queue_value(12'd2187);
        queue_value(12'd3969);
        queue_value(12'd2310);
        queue_value(12'd961);
        queue_value(12'd4087);
        queue_value(12'd3481);
        queue_value(12'd1024);
        queue_value(12'd6);
        queue_value(12'h555);
        queue_value(12'hAAA);
        queue_value(12'd0);
        queue_value(12'd4032);
        wait_all_sent();
        wait_drained();

        // Stall the result side while the sender keeps offering
        idle_pct = 0;
        -> hold_request;
        repeat (20) queue_value(draw_value());
        wait_all_sent();
        wait_drained();

        // Random values with idling on both sides
        idle_pct = IDLE_PCT;
        repeat (30) queue_value(draw_value());
        wait_all_sent();

        // Random values with no idling at all
        @(negedge clk);
        idle_pct = 0;
        repeat (30) queue_value(draw_value());
        wait_all_sent();
        wait_drained();

        // Catch any stray transfers after the last expected factor
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d values and %0d result transfers (%0d without factors)",
            values_accepted, factors_checked, empties_checked);
        $display("longest list %0d factors; one %0d-cycle result hold-off",
            most_factors, HOLD_CYCLES);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4ms;
        $display("watchdog expired with %0d factors outstanding", expected_factors.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
